// ===== sv/cdq_pkg.sv =====
package cdq_pkg;

  localparam int unsigned IdWidth = 16;

  typedef enum logic [2:0] {
    FN_ADD       = 3'd0,
    FN_POLL_ALL  = 3'd1,
    FN_POLL_DOG  = 3'd2,
    FN_POLL_CAT  = 3'd3,
    FN_BOTH_EMPTY = 3'd4,
    FN_DOG_EMPTY = 3'd5,
    FN_CAT_EMPTY = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    RK_DEQUEUE = 2'd0,
    RK_ANSWER  = 2'd1,
    RK_DROP    = 2'd2
  } result_kind_e;

  typedef enum logic [0:0] {
    CLS_CAT = 1'b0,
    CLS_DOG = 1'b1
  } class_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  // occupancy flags of one class queue
  typedef struct packed {
    logic empty;
    logic full;
    logic one_left;
  } cdq_stat_t;

endpackage

// ===== sv/two_class_fifo_arrival_merge.sv =====
// Adds and empty queries leave busy low; the next item may follow at once.
// A drain of n entries is accepted and then pops one entry per cycle, with busy high for
// its n pops. Each result appears in the cycle after its pop or accept.
// The head of each queue is read from its memory into a register ahead of its pop, which sets the pop rate.
// Reset (rst_ni low, asynchronous) empties both queues and clears the arrival counter.
// Results are strobed for one cycle on result_valid_o; the receiver cannot stall.
module two_class_fifo_arrival_merge import cdq_pkg::*; #(
  parameter int unsigned CLASS_DEPTH = 16,
  parameter int unsigned SEQ_WIDTH   = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         func_i,
  input  logic               pet_kind_i,
  input  logic [IdWidth-1:0] pet_id_i,
  output logic               result_valid_o,
  output logic [1:0]         result_kind_o,
  output logic               out_class_o,
  output logic [IdWidth-1:0] out_id_o,
  output logic               answer_yes_o,
  output logic               last_of_run_o
);

  state_e state_q, state_d;
  func_e  mode_q, mode_d;
  func_e  func;

  logic [SEQ_WIDTH-1:0] arrival_q, arrival_d;

  logic                 cat_push, dog_push, cat_pop, dog_pop;
  logic [IdWidth-1:0]   cat_id, dog_id;
  logic [SEQ_WIDTH-1:0] cat_seq, dog_seq, seq_diff;
  cdq_stat_t            cat_st, dog_st;

  logic               accept, sel_dog, drain_last, add_full;
  logic               res_valid_q, res_valid_d;
  result_kind_e       res_kind_q, res_kind_d;
  logic               res_class_q, res_class_d;
  logic [IdWidth-1:0] res_id_q, res_id_d;
  logic               res_yes_q, res_yes_d;
  logic               res_last_q, res_last_d;

  cdq_fifo #(.CLASS_DEPTH(CLASS_DEPTH), .SEQ_WIDTH(SEQ_WIDTH)) u_cat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cat_push),
    .push_id_i  (pet_id_i),
    .push_seq_i (arrival_q),
    .pop_i      (cat_pop),
    .head_id_o  (cat_id),
    .head_seq_o (cat_seq),
    .stat_o     (cat_st)
  );

  cdq_fifo #(.CLASS_DEPTH(CLASS_DEPTH), .SEQ_WIDTH(SEQ_WIDTH)) u_dog (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (dog_push),
    .push_id_i  (pet_id_i),
    .push_seq_i (arrival_q),
    .pop_i      (dog_pop),
    .head_id_o  (dog_id),
    .head_seq_o (dog_seq),
    .stat_o     (dog_st)
  );

  assign busy   = (state_q == ST_DRAIN);
  assign accept = start && !busy;
  assign func   = func_e'(func_i);

  assign add_full = (pet_kind_i == CLS_DOG) ? dog_st.full : cat_st.full;
  assign cat_push = accept && (func == FN_ADD) && (pet_kind_i == CLS_CAT) && !cat_st.full;
  assign dog_push = accept && (func == FN_ADD) && (pet_kind_i == CLS_DOG) && !dog_st.full;

  // older head leaves first: cat wins when cat_seq - dog_seq is negative
  assign seq_diff = cat_seq - dog_seq;

  always_comb begin
    case (mode_q)
      FN_POLL_DOG: sel_dog = 1'b1;
      FN_POLL_CAT: sel_dog = 1'b0;
      default: begin
        if (!cat_st.empty && !dog_st.empty) begin
          sel_dog = !seq_diff[SEQ_WIDTH-1];
        end else begin
          sel_dog = !dog_st.empty;
        end
      end
    endcase
  end

  always_comb begin
    case (mode_q)
      FN_POLL_DOG: drain_last = dog_st.one_left;
      FN_POLL_CAT: drain_last = cat_st.one_left;
      default:     drain_last = (cat_st.one_left && dog_st.empty) ||
                                (dog_st.one_left && cat_st.empty);
    endcase
  end

  assign cat_pop = (state_q == ST_DRAIN) && !sel_dog;
  assign dog_pop = (state_q == ST_DRAIN) && sel_dog;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    arrival_d   = arrival_q;
    res_valid_d = 1'b0;
    res_kind_d  = RK_DEQUEUE;
    res_class_d = CLS_CAT;
    res_id_d    = '0;
    res_yes_d   = 1'b0;
    res_last_d  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func)
            FN_ADD: begin
              if (add_full) begin
                res_valid_d = 1'b1;
                res_kind_d  = RK_DROP;
                res_class_d = pet_kind_i;
                res_id_d    = pet_id_i;
              end else begin
                arrival_d = arrival_q + SEQ_WIDTH'(1);
              end
            end
            FN_POLL_ALL: begin
              mode_d = func;
              if (!cat_st.empty || !dog_st.empty) begin
                state_d = ST_DRAIN;
              end
            end
            FN_POLL_DOG: begin
              mode_d = func;
              if (!dog_st.empty) begin
                state_d = ST_DRAIN;
              end
            end
            FN_POLL_CAT: begin
              mode_d = func;
              if (!cat_st.empty) begin
                state_d = ST_DRAIN;
              end
            end
            FN_BOTH_EMPTY: begin
              res_valid_d = 1'b1;
              res_kind_d  = RK_ANSWER;
              res_yes_d   = cat_st.empty && dog_st.empty;
            end
            FN_DOG_EMPTY: begin
              res_valid_d = 1'b1;
              res_kind_d  = RK_ANSWER;
              res_yes_d   = dog_st.empty;
            end
            FN_CAT_EMPTY: begin
              res_valid_d = 1'b1;
              res_kind_d  = RK_ANSWER;
              res_yes_d   = cat_st.empty;
            end
            default: ;
          endcase
        end
      end
      ST_DRAIN: begin
        res_valid_d = 1'b1;
        res_kind_d  = RK_DEQUEUE;
        res_class_d = sel_dog;
        res_id_d    = sel_dog ? dog_id : cat_id;
        res_last_d  = drain_last;
        if (drain_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= FN_POLL_ALL;
      arrival_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      arrival_q   <= arrival_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q  <= res_kind_d;
    res_class_q <= res_class_d;
    res_id_q    <= res_id_d;
    res_yes_q   <= res_yes_d;
    res_last_q  <= res_last_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_kind_o  = res_kind_q;
  assign out_class_o    = res_class_q;
  assign out_id_o       = res_id_q;
  assign answer_yes_o   = res_yes_q;
  assign last_of_run_o  = res_last_q;

  // a drain cycle always has an entry to pop from the selected queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> (sel_dog ? !dog_st.empty : !cat_st.empty))
    else $error("drain pops an empty queue");

  // only a drain produces a result that is not last of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_of_run_o |-> state_q == ST_DRAIN)
    else $error("non-final result outside a drain");

  // a drain starts with no result pending from its accept cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> !result_valid_o)
    else $error("result emitted on poll accept");

endmodule

// ===== sv/cdq_fifo.sv =====
module cdq_fifo import cdq_pkg::*; #(
  parameter int unsigned CLASS_DEPTH = 16,
  parameter int unsigned SEQ_WIDTH   = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [IdWidth-1:0]   push_id_i,
  input  logic [SEQ_WIDTH-1:0] push_seq_i,
  input  logic                 pop_i,
  output logic [IdWidth-1:0]   head_id_o,
  output logic [SEQ_WIDTH-1:0] head_seq_o,
  output cdq_stat_t            stat_o
);

  localparam int unsigned IdxW = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(CLASS_DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam int unsigned EntW = IdWidth + SEQ_WIDTH;

  logic [EntW-1:0] mem_q [CLASS_DEPTH];
  logic [EntW-1:0] rd_q;
  logic [EntW-1:0] wr_data;
  logic [IdxW-1:0] head_q, head_d, tail;
  logic [CntW-1:0] count_q, count_d;
  logic [SumW-1:0] tail_sum, tail_wrap;
  logic            wr_en;

  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q == CntW'(CLASS_DEPTH));
  assign stat_o.one_left = (count_q == CntW'(1));

  assign wr_en   = push_i && !stat_o.full;
  assign wr_data = {push_id_i, push_seq_i};

  // tail = (head + count) mod depth; the sum stays below twice the depth
  assign tail_sum  = SumW'(head_q) + SumW'(count_q);
  assign tail_wrap = (tail_sum >= SumW'(CLASS_DEPTH)) ? tail_sum - SumW'(CLASS_DEPTH)
                                                       : tail_sum;
  assign tail      = tail_wrap[IdxW-1:0];

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (pop_i && !stat_o.empty) begin
      head_d = (head_q == IdxW'(CLASS_DEPTH - 1)) ? '0 : head_q + IdxW'(1);
    end
    if (wr_en && !(pop_i && !stat_o.empty)) begin
      count_d = count_q + CntW'(1);
    end else if (!wr_en && pop_i && !stat_o.empty) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // read the next head every cycle; forward a write that lands on it
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tail] <= wr_data;
    end
    if (wr_en && (tail == head_d)) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= mem_q[head_d];
    end
  end

  assign head_id_o  = rd_q[EntW-1:SEQ_WIDTH];
  assign head_seq_o = rd_q[SEQ_WIDTH-1:0];

endmodule
